FILE: rtl/core/fcfs_pkg.sv
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared widths, record types and controller/datapath links for the
// first-come-first-served wait and turnaround calculator.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int WAIT_W = 24;
    localparam int SUM_W  = 30;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [ID_W-1:0]   served_id;
        logic [TIME_W-1:0] served_arrival;
        logic [TIME_W-1:0] served_burst;
        logic [WAIT_W-1:0] wait_time;
        logic [WAIT_W-1:0] turnaround_time;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_turnaround;
        logic              overflow_flag;
        logic              last_result;
    } result_t;

    typedef struct packed {
        logic capture;
        logic set_dropped;
        logic pos_init;
        logic rd_prev;
        logic wr_shift;
        logic wr_item;
        logic pass_init;
        logic rd_idx;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic item_last;
        logic pos_zero;
        logic shift_needed;
        logic out_free;
        logic pass_last;
    } status_t;

endpackage

FILE: rtl/core/fcfs_in_if.sv
// ----------------------------------------------------------------------------
// fcfs_in_if
// Request channel carrying one process description per transfer.
// ----------------------------------------------------------------------------
interface fcfs_in_if import fcfs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
    logic              last_item;

    modport source (
        output valid, process_id, arrival_time, burst_time, last_item,
        input  ready
    );

    modport sink (
        input  valid, process_id, arrival_time, burst_time, last_item,
        output ready
    );

endinterface

FILE: rtl/core/fcfs_out_if.sv
// ----------------------------------------------------------------------------
// fcfs_out_if
// Result channel carrying one served process record per transfer.
// ----------------------------------------------------------------------------
interface fcfs_out_if import fcfs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   served_id;
    logic [TIME_W-1:0] served_arrival;
    logic [TIME_W-1:0] served_burst;
    logic [WAIT_W-1:0] wait_time;
    logic [WAIT_W-1:0] turnaround_time;
    logic [SUM_W-1:0]  total_wait;
    logic [SUM_W-1:0]  total_turnaround;
    logic              overflow_flag;
    logic              last_result;

    modport source (
        output valid, served_id, served_arrival, served_burst, wait_time,
               turnaround_time, total_wait, total_turnaround, overflow_flag,
               last_result,
        input  ready
    );

    modport sink (
        input  valid, served_id, served_arrival, served_burst, wait_time,
               turnaround_time, total_wait, total_turnaround, overflow_flag,
               last_result,
        output ready
    );

endinterface

FILE: rtl/core/fcfs_ram.sv
// ----------------------------------------------------------------------------
// fcfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fcfs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fcfs_ctrl.sv
// ----------------------------------------------------------------------------
// fcfs_ctrl
// Sequencer for ordered insertion of loads and the serving pass.
// ----------------------------------------------------------------------------
module fcfs_ctrl import fcfs_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        LOAD_CHECK,
        INS_PROBE,
        INS_CMP,
        INS_PLACE,
        PASS_START,
        PASS_READ,
        PASS_CALC
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = LOAD_CHECK;
                end
            end
            LOAD_CHECK:
            begin
                if (status.full)
                begin
                    cmd.set_dropped = 1'b1;
                    state_next      = status.item_last ? PASS_START : IDLE;
                end
                else
                begin
                    cmd.pos_init = 1'b1;
                    state_next   = INS_PROBE;
                end
            end
            INS_PROBE:
            begin
                if (status.pos_zero)
                begin
                    state_next = INS_PLACE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = INS_CMP;
                end
            end
            INS_CMP:
            begin
                if (status.shift_needed)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = INS_PROBE;
                end
                else
                begin
                    state_next = INS_PLACE;
                end
            end
            INS_PLACE:
            begin
                cmd.wr_item = 1'b1;
                state_next  = status.item_last ? PASS_START : IDLE;
            end
            PASS_START:
            begin
                cmd.pass_init = 1'b1;
                state_next    = PASS_READ;
            end
            PASS_READ:
            begin
                cmd.rd_idx = 1'b1;
                state_next = PASS_CALC;
            end
            PASS_CALC:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.pass_last ? IDLE : PASS_READ;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/fcfs_dp.sv
// ----------------------------------------------------------------------------
// fcfs_dp
// Process table, insertion pointer, serving arithmetic and result register.
// ----------------------------------------------------------------------------
module fcfs_dp import fcfs_pkg::*; #(
    parameter int MAX_PROCESSES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ID_W-1:0]   process_id,
    input  logic [TIME_W-1:0] arrival_time,
    input  logic [TIME_W-1:0] burst_time,
    input  logic              last_item,
    input  cmd_t              cmd,
    output status_t           status,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           result
);

    localparam int AW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    entry_t              item_reg;
    logic                item_last_reg;
    logic [CW-1:0]       pos_reg;
    logic [CW-1:0]       pos_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                dropped_reg;
    logic                dropped_next;
    logic [AW-1:0]       idx_reg;
    logic [AW-1:0]       idx_next;
    logic [WAIT_W-1:0]   finish_reg;
    logic [WAIT_W-1:0]   finish_next;
    logic [SUM_W-1:0]    wsum_reg;
    logic [SUM_W-1:0]    wsum_next;
    logic [SUM_W-1:0]    tsum_reg;
    logic [SUM_W-1:0]    tsum_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             result_reg;

    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;
    logic [CW-1:0]       pos_m1;

    logic [WAIT_W-1:0]   arr_ext;
    logic [WAIT_W-1:0]   start_time;
    logic [WAIT_W-1:0]   wait_val;
    logic [WAIT_W:0]     tat_full;
    logic [WAIT_W-1:0]   tat_val;
    logic [WAIT_W:0]     fin_full;
    logic [WAIT_W-1:0]   fin_val;
    logic [SUM_W:0]      wsum_full;
    logic [SUM_W-1:0]    wsum_val;
    logic [SUM_W:0]      tsum_full;
    logic [SUM_W-1:0]    tsum_val;
    logic                pass_last;

    assign rd_entry = entry_t'(ram_rdata);
    assign pos_m1   = pos_reg - CW'(1);

    assign ram_we    = cmd.wr_shift | cmd.wr_item;
    assign ram_waddr = pos_reg[AW-1:0];
    assign ram_wdata = cmd.wr_shift ? ram_rdata : ENTRY_W'(item_reg);
    assign ram_re    = cmd.rd_prev | cmd.rd_idx;
    assign ram_raddr = cmd.rd_prev ? pos_m1[AW-1:0] : idx_reg;

    fcfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCESSES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign arr_ext    = WAIT_W'(rd_entry.arrival);
    assign start_time = ((idx_reg == '0) || (finish_reg < arr_ext)) ? arr_ext : finish_reg;
    assign wait_val   = start_time - arr_ext;
    assign tat_full   = {1'b0, wait_val} + (WAIT_W + 1)'(rd_entry.burst);
    assign tat_val    = tat_full[WAIT_W] ? '1 : tat_full[WAIT_W-1:0];
    assign fin_full   = {1'b0, start_time} + (WAIT_W + 1)'(rd_entry.burst);
    assign fin_val    = fin_full[WAIT_W] ? '1 : fin_full[WAIT_W-1:0];
    assign wsum_full  = {1'b0, wsum_reg} + (SUM_W + 1)'(wait_val);
    assign wsum_val   = wsum_full[SUM_W] ? '1 : wsum_full[SUM_W-1:0];
    assign tsum_full  = {1'b0, tsum_reg} + (SUM_W + 1)'(tat_val);
    assign tsum_val   = tsum_full[SUM_W] ? '1 : tsum_full[SUM_W-1:0];
    assign pass_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign status.full         = (count_reg == CW'(MAX_PROCESSES));
    assign status.item_last    = item_last_reg;
    assign status.pos_zero     = (pos_reg == '0);
    assign status.shift_needed = (rd_entry.arrival > item_reg.arrival) ||
                                 ((rd_entry.arrival == item_reg.arrival) &&
                                  (rd_entry.id > item_reg.id));
    assign status.out_free     = !out_valid_reg || out_ready;
    assign status.pass_last    = pass_last;

    always_comb
    begin
        pos_next       = pos_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        idx_next       = idx_reg;
        finish_next    = finish_reg;
        wsum_next      = wsum_reg;
        tsum_next      = tsum_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.set_dropped)
        begin
            dropped_next = 1'b1;
        end
        if (cmd.pos_init)
        begin
            pos_next = count_reg;
        end
        if (cmd.wr_shift)
        begin
            pos_next = pos_m1;
        end
        if (cmd.wr_item)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pass_init)
        begin
            idx_next = '0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (pass_last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
                finish_next  = '0;
                wsum_next    = '0;
                tsum_next    = '0;
            end
            else
            begin
                idx_next    = idx_reg + AW'(1);
                finish_next = fin_val;
                wsum_next   = wsum_val;
                tsum_next   = tsum_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            idx_reg       <= '0;
            finish_reg    <= '0;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            out_valid_reg <= 1'b0;
            item_last_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            idx_reg       <= idx_next;
            finish_reg    <= finish_next;
            wsum_reg      <= wsum_next;
            tsum_reg      <= tsum_next;
            out_valid_reg <= out_valid_next;
            if (cmd.capture)
            begin
                item_last_reg <= last_item;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg.id      <= process_id;
            item_reg.arrival <= arrival_time;
            item_reg.burst   <= burst_time;
        end
        if (cmd.emit)
        begin
            result_reg.served_id        <= rd_entry.id;
            result_reg.served_arrival   <= rd_entry.arrival;
            result_reg.served_burst     <= rd_entry.burst;
            result_reg.wait_time        <= wait_val;
            result_reg.turnaround_time  <= tat_val;
            result_reg.total_wait       <= wsum_val;
            result_reg.total_turnaround <= tsum_val;
            result_reg.overflow_flag    <= dropped_reg;
            result_reg.last_result      <= pass_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

FILE: rtl/core/fcfs_wait_turnaround_calculator_unit.sv
// ----------------------------------------------------------------------------
// fcfs_wait_turnaround_calculator_unit
// First-come-first-served scheduler: loads processes into an arrival-ordered
// table and, on the last load, emits wait and turnaround figures per process.
// ----------------------------------------------------------------------------
// Loading: an accepted process is placed in arrival order, and each stored entry
// that must follow it moves up one slot; a load that finds the table full is
// dropped. No new process is accepted until the current load or pass finishes.
// The serving pass reads one table entry at a time through the registered RAM
// port and holds each result until the output channel takes it.
// Reset clears the counts, totals and drop marker; the table is not cleared.
module fcfs_wait_turnaround_calculator_unit import fcfs_pkg::*; #(
    parameter int MAX_PROCESSES = 32
) (
    input logic         clk,
    input logic         rst_n,
    fcfs_in_if.sink     proc_chan,
    fcfs_out_if.source  result_chan
);

    cmd_t    cmd;
    status_t status;
    result_t result;

    fcfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (proc_chan.valid),
        .in_ready (proc_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    fcfs_dp #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .process_id   (proc_chan.process_id),
        .arrival_time (proc_chan.arrival_time),
        .burst_time   (proc_chan.burst_time),
        .last_item    (proc_chan.last_item),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (result_chan.valid),
        .out_ready    (result_chan.ready),
        .result       (result)
    );

    assign result_chan.served_id        = result.served_id;
    assign result_chan.served_arrival   = result.served_arrival;
    assign result_chan.served_burst     = result.served_burst;
    assign result_chan.wait_time        = result.wait_time;
    assign result_chan.turnaround_time  = result.turnaround_time;
    assign result_chan.total_wait       = result.total_wait;
    assign result_chan.total_turnaround = result.total_turnaround;
    assign result_chan.overflow_flag    = result.overflow_flag;
    assign result_chan.last_result      = result.last_result;

endmodule
